// ===== src/spp_pkg.sv =====
// Shared types and constants for the spectral peak picker.
`timescale 1ns / 1ps

package spp_pkg;

  localparam int MAG_W  = 24;
  localparam int IDX_W  = 12;
  localparam int PCNT_W = 13;
  localparam int CFG_W  = 4;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PCNT_W-1:0] pcnt_t;
  typedef logic [CFG_W-1:0]  span_cfg_t;

  localparam span_cfg_t SPAN_RST  = 4'd2;
  localparam pcnt_t     COUNT_MAX = {PCNT_W{1'b1}};

  // result kinds
  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_END  = 1'b1;

endpackage

// ===== src/spp_if.sv =====
// Stream and configuration channel interfaces of the spectral peak picker.
`timescale 1ns / 1ps

interface spp_in_if import spp_pkg::*; ();
  logic valid;
  logic ready;
  mag_t magnitude;
  logic last;

  modport source (output valid, magnitude, last, input ready);
  modport sink   (input valid, magnitude, last, output ready);
endinterface

interface spp_out_if import spp_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  idx_t  peak_index;
  pcnt_t peak_count;
  logic  last_res;

  modport source (output valid, kind, peak_index, peak_count, last_res, input ready);
  modport sink   (input valid, kind, peak_index, peak_count, last_res, output ready);
endinterface

interface spp_cfg_if import spp_pkg::*; ();
  logic      valid;
  logic      ready;
  span_cfg_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/spectral_peak_picker.sv =====
// Spectral peak picker top level: bin line, frame control and result register.
`timescale 1ns / 1ps

// Takes one magnitude bin per cycle unless in_ready is low, and reports a
// bin as a peak once span later bins have arrived. The span is sampled
// when a frame's first bin is taken and
// is clipped to MAX_SPAN. Input words stream back to back; the output is a
// single register, so in_ready falls when a decision is waiting on a
// stalled output. A word marked last also holds off input: the bin line is
// stepped once per cycle, while the output does not stall, to decide the
// remaining span bins, then the end-of-frame word with the peak count is sent.
// Bins beyond MAX_BINS are ignored, though a last flag on them still ends
// the frame. Configuration writes are always accepted.
module spectral_peak_picker import spp_pkg::*; #(
  parameter int MAX_BINS = 4096,
  parameter int MAX_SPAN = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  spp_in_if.sink        in_bus,
  spp_out_if.source     out_bus,
  spp_cfg_if.sink       cfg_bus
);

  localparam int LINE_DEPTH = 2 * MAX_SPAN + 1;
  localparam int SPAN_W     = $clog2(MAX_SPAN + 1);
  localparam int POS_W      = $clog2(MAX_BINS + MAX_SPAN + 1);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_MARK  = 2'd2;

  logic [1:0]                        st_r, st_nxt;
  span_cfg_t                         cfg_span_r;
  logic [SPAN_W-1:0]                 span_r, span_nxt, span_sat;
  logic [SPAN_W-1:0]                 flush_left_r, flush_left_nxt;
  logic [POS_W-1:0]                  pos_cnt_r, pos_cnt_nxt;
  logic [POS_W-1:0]                  ctr_idx;
  pcnt_t                             peaks_r, peaks_nxt;
  logic [LINE_DEPTH-1:0][MAG_W-1:0]  line_r, line_nxt;
  logic [LINE_DEPTH-1:0]             vld_r, vld_nxt;
  logic                              dec_pend_r, dec_pend_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_kind_r, out_kind_nxt;
  idx_t                              out_idx_r, out_idx_nxt;
  pcnt_t                             out_cnt_r, out_cnt_nxt;
  logic                              out_last_r, out_last_nxt;

  logic out_free, dec_done, dec_emit, mark_emit, in_fire, is_peak;

  spp_peak_cmp #(.MAX_SPAN(MAX_SPAN)) u_cmp (
    .line    (line_r),
    .vld     (vld_r),
    .span    (span_r),
    .is_peak (is_peak)
  );

  assign cfg_bus.ready = 1'b1;

  assign out_free  = !out_valid_r || out_bus.ready;
  assign dec_done  = !dec_pend_r || out_free;
  assign dec_emit  = dec_pend_r && out_free && is_peak;
  assign mark_emit = (st_r == ST_MARK) && out_free;
  assign in_bus.ready = (st_r == ST_RUN) && dec_done;
  assign in_fire   = in_bus.valid && in_bus.ready;
  assign span_sat  = (int'(cfg_span_r) > MAX_SPAN) ? SPAN_W'(MAX_SPAN) : SPAN_W'(cfg_span_r);
  assign ctr_idx   = pos_cnt_r - POS_W'(span_r) - POS_W'(1);

  always_comb begin
    st_nxt         = st_r;
    span_nxt       = span_r;
    flush_left_nxt = flush_left_r;
    pos_cnt_nxt    = pos_cnt_r;
    line_nxt       = line_r;
    vld_nxt        = vld_r;
    dec_pend_nxt   = dec_pend_r && !out_free;
    peaks_nxt      = peaks_r;
    if (dec_emit && (peaks_r != COUNT_MAX)) begin
      peaks_nxt = peaks_r + pcnt_t'(1);
    end

    unique case (st_r)
      ST_RUN: begin
        if (in_fire) begin
          if (pos_cnt_r < POS_W'(MAX_BINS)) begin
            if (pos_cnt_r == '0) begin
              span_nxt = span_sat;
            end
            line_nxt     = {line_r[LINE_DEPTH-2:0], in_bus.magnitude};
            vld_nxt      = {vld_r[LINE_DEPTH-2:0], 1'b1};
            pos_cnt_nxt  = pos_cnt_r + POS_W'(1);
            dec_pend_nxt = 1'b1;
          end
          if (in_bus.last) begin
            st_nxt         = ST_FLUSH;
            flush_left_nxt = span_nxt;
          end
        end
      end
      ST_FLUSH: begin
        // step past the frame end, one remaining bin per cycle unless the output stalls
        if (dec_done) begin
          if (flush_left_r != '0) begin
            line_nxt       = {line_r[LINE_DEPTH-2:0], {MAG_W{1'b0}}};
            vld_nxt        = {vld_r[LINE_DEPTH-2:0], 1'b0};
            pos_cnt_nxt    = pos_cnt_r + POS_W'(1);
            flush_left_nxt = flush_left_r - SPAN_W'(1);
            dec_pend_nxt   = 1'b1;
          end else begin
            st_nxt = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          vld_nxt     = '0;
          pos_cnt_nxt = '0;
          peaks_nxt   = '0;
          st_nxt      = ST_RUN;
        end
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    if (dec_emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_PEAK;
      out_idx_nxt   = IDX_W'(ctr_idx);
      out_cnt_nxt   = '0;
      out_last_nxt  = 1'b0;
    end else if (mark_emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_END;
      out_idx_nxt   = '0;
      out_cnt_nxt   = peaks_r;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_RUN;
      cfg_span_r   <= SPAN_RST;
      span_r       <= '0;
      flush_left_r <= '0;
      pos_cnt_r    <= '0;
      peaks_r      <= '0;
      vld_r        <= '0;
      dec_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      if (cfg_bus.valid && cfg_bus.ready) begin
        cfg_span_r <= cfg_bus.data;
      end
      span_r       <= span_nxt;
      flush_left_r <= flush_left_nxt;
      pos_cnt_r    <= pos_cnt_nxt;
      peaks_r      <= peaks_nxt;
      vld_r        <= vld_nxt;
      dec_pend_r   <= dec_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r     <= line_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.kind       = out_kind_r;
  assign out_bus.peak_index = out_idx_r;
  assign out_bus.peak_count = out_cnt_r;
  assign out_bus.last_res   = out_last_r;

  // end word is only sent after every decision of the frame has drained
  a_mark_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MARK) |-> !dec_pend_r)
    else $error("decision pending while sending end word");

  // a taken end word leaves the frame counters cleared
  a_mark_clears: assert property (@(posedge clk) disable iff (!rst_n)
    mark_emit |=> (st_r == ST_RUN) && (pos_cnt_r == '0) && (peaks_r == '0) && (vld_r == '0))
    else $error("frame state not cleared after end word");

  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FLUSH) |-> (flush_left_r <= span_r))
    else $error("flush step count above span");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_cnt_r <= POS_W'(MAX_BINS + MAX_SPAN))
    else $error("bin position counter out of range");

  // a peak word always comes from a bin that lies inside the frame
  a_peak_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    dec_emit |-> (pos_cnt_r > POS_W'(span_r)))
    else $error("peak reported for a bin before frame start");

endmodule

// ===== src/spp_peak_cmp.sv =====
// Window compare: decides whether the center tap of the bin line is a peak.
`timescale 1ns / 1ps

module spp_peak_cmp import spp_pkg::*; #(
  parameter int MAX_SPAN = 8
) (
  input  logic [2*MAX_SPAN:0][MAG_W-1:0] line,
  input  logic [2*MAX_SPAN:0]            vld,
  input  logic [$clog2(MAX_SPAN+1)-1:0]  span,
  output logic                           is_peak
);

  localparam int LINE_DEPTH = 2 * MAX_SPAN + 1;
  localparam int LD_W       = $clog2(LINE_DEPTH);

  logic [LD_W-1:0]       ctr;
  logic [LD_W-1:0]       far;
  mag_t                  cand;
  logic [LINE_DEPTH-1:0] lose;

  // taps below the center are later bins (cand must be >=), taps above are
  // earlier bins (cand must be strictly >); invalid taps are outside the frame
  always_comb begin
    ctr  = LD_W'(span);
    far  = LD_W'({span, 1'b0});
    cand = line[ctr];
    for (int p = 0; p < LINE_DEPTH; p++) begin
      if (LD_W'(p) < ctr) begin
        lose[p] = vld[p] && (line[p] > cand);
      end else if ((LD_W'(p) > ctr) && (LD_W'(p) <= far)) begin
        lose[p] = vld[p] && (line[p] >= cand);
      end else begin
        lose[p] = 1'b0;
      end
    end
    is_peak = vld[ctr] && !(|lose);
  end

endmodule

// ===== sim/spectral_peak_picker_tb.sv =====
// Self-checking testbench for the spectral peak picker: bin streams, span changes, stalls.
`timescale 1ns / 1ps

module spectral_peak_picker_tb;
  import spp_pkg::*;

  localparam int          MAX_BINS     = 4096;
  localparam int          MAX_SPAN     = 8;
  localparam int          LINE_DEPTH   = 2 * MAX_SPAN + 1;
  localparam int          RANDOM_ITEMS = 290;
  localparam int          QUIET_CYCLES = 2 * MAX_SPAN + 8;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          PRESS_LEN    = 48;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          SHOW_MAX     = 10;
  localparam mag_t        MAG_TOP      = '1;

  // magnitude patterns for a frame
  localparam int MAG_FULL    = 0;
  localparam int MAG_TIES    = 1;
  localparam int MAG_EXTREME = 2;
  localparam int MAG_SMALL   = 3;
  localparam int MAG_ALT     = 4;

  typedef struct packed {
    logic  kind;
    idx_t  peak_index;
    pcnt_t peak_count;
    logic  last_res;
  } peak_word_t;

  // Predicts peak and end-of-frame words and checks them in order.
  class peak_tracker;
    mag_t        bin_line[LINE_DEPTH];   // newest first
    int unsigned bins_held;
    int unsigned peak_tally;
    int unsigned frame_span;
    span_cfg_t   span_reg;
    peak_word_t  pending_words[$];
    int unsigned errors;
    int unsigned peaks_ok;
    int unsigned markers_ok;
    int unsigned bins_seen;
    int unsigned span_writes;

    function new();
      foreach (bin_line[i]) bin_line[i] = '0;
      bins_held   = 0;
      peak_tally  = 0;
      frame_span  = 0;
      span_reg    = SPAN_RST;
      errors      = 0;
      peaks_ok    = 0;
      markers_ok  = 0;
      bins_seen   = 0;
      span_writes = 0;
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    function void set_span(span_cfg_t v);
      span_reg = v;
      span_writes++;
    endfunction

    function mag_t bin_at(int unsigned b);
      int unsigned d;
      d = bins_held - 1 - b;
      if (b >= bins_held || d >= LINE_DEPTH) return '0;
      return bin_line[d];
    endfunction

    // first maximum: strictly above earlier bins, not below later ones
    function bit bin_is_peak(int unsigned k, int unsigned hi);
      int unsigned lo;
      int unsigned j;
      mag_t        v;
      lo = (k >= frame_span) ? k - frame_span : 0;
      v  = bin_at(k);
      for (j = lo; j < k; j++)
        if (bin_at(j) >= v) return 1'b0;
      for (j = k + 1; j <= hi; j++)
        if (bin_at(j) > v) return 1'b0;
      return 1'b1;
    endfunction

    function void decide(int unsigned k, int unsigned hi);
      peak_word_t w;
      if (!bin_is_peak(k, hi)) return;
      w.kind       = KIND_PEAK;
      w.peak_index = idx_t'(k);
      w.peak_count = '0;
      w.last_res   = 1'b0;
      pending_words.push_back(w);
      if (peak_tally < COUNT_MAX) peak_tally++;
    endfunction

    function void note_bin(mag_t m, logic is_last);
      bit          stored;
      int          i;
      int unsigned first;
      int unsigned k;
      int unsigned hi;
      peak_word_t  w;
      stored = 1'b0;
      bins_seen++;
      if (bins_held < MAX_BINS) begin
        if (bins_held == 0)
          frame_span = (span_reg > MAX_SPAN) ? MAX_SPAN : int'(span_reg);
        for (i = LINE_DEPTH - 1; i > 0; i--) bin_line[i] = bin_line[i-1];
        bin_line[0] = m;
        bins_held++;
        stored = 1'b1;
      end
      if (!is_last) begin
        if (stored && bins_held - 1 >= frame_span)
          decide(bins_held - 1 - frame_span, bins_held - 1);
        return;
      end
      // flush: decide every bin still waiting on later neighbours
      if (stored)
        first = (bins_held - 1 >= frame_span) ? bins_held - 1 - frame_span : 0;
      else
        first = (bins_held >= frame_span) ? bins_held - frame_span : 0;
      for (k = first; k < bins_held; k++) begin
        hi = (k + frame_span > bins_held - 1) ? bins_held - 1 : k + frame_span;
        decide(k, hi);
      end
      w.kind       = KIND_END;
      w.peak_index = '0;
      w.peak_count = pcnt_t'(peak_tally);
      w.last_res   = 1'b1;
      pending_words.push_back(w);
      bins_held  = 0;
      peak_tally = 0;
    endfunction

    function void report_bad(string msg);
      errors++;
      if (errors <= SHOW_MAX) $display("ERROR: %s", msg);
    endfunction

    function void check_word(logic kind, idx_t idx, pcnt_t cnt, logic lr);
      peak_word_t want;
      if (pending_words.size() == 0) begin
        report_bad($sformatf("unexpected word kind=%0d idx=%0d cnt=%0d last=%0d",
                             kind, idx, cnt, lr));
        return;
      end
      want = pending_words.pop_front();
      if (kind !== want.kind || idx !== want.peak_index ||
          cnt !== want.peak_count || lr !== want.last_res)
        report_bad($sformatf({"word mismatch: expected kind=%0d idx=%0d cnt=%0d last=%0d,",
                              " got kind=%0d idx=%0d cnt=%0d last=%0d"},
                             want.kind, want.peak_index, want.peak_count, want.last_res,
                             kind, idx, cnt, lr));
      else if (want.kind == KIND_END)
        markers_ok++;
      else
        peaks_ok++;
    endfunction

    function void flush_leftovers();
      peak_word_t w;
      while (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        report_bad($sformatf("missing word kind=%0d idx=%0d cnt=%0d",
                             w.kind, w.peak_index, w.peak_count));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        hold_off_req;
  logic        snk_idle_en;
  bit          src_idle_en;
  int unsigned cycle_count;
  int unsigned rand_items;
  int unsigned frame_no;
  int unsigned len;

  peak_tracker tracker = new();

  spp_in_if  in_bus ();
  spp_out_if out_bus ();
  spp_cfg_if cfg_bus ();

  spectral_peak_picker #(
    .MAX_BINS (MAX_BINS),
    .MAX_SPAN (MAX_SPAN)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, tracker.pending());
      $display("spectral_peak_picker regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) tracker.set_span(cfg_bus.data);
      if (in_bus.valid && in_bus.ready) tracker.note_bin(in_bus.magnitude, in_bus.last);
      if (out_bus.valid && out_bus.ready)
        tracker.check_word(out_bus.kind, out_bus.peak_index, out_bus.peak_count,
                           out_bus.last_res);
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req <= 1'b0;
      end else begin
        if (stall_left == 0 && snk_idle_en && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 8);
        if (stall_left > 0) begin
          stall_left--;
          out_bus.ready <= 1'b0;
        end else begin
          out_bus.ready <= 1'b1;
        end
      end
    end
  end

  function automatic mag_t pick_mag(int style, int unsigned pos);
    case (style)
      MAG_TIES:    return mag_t'($urandom_range(0, 3));
      MAG_EXTREME: return ($urandom_range(0, 1) != 0) ? MAG_TOP : mag_t'(0);
      MAG_SMALL:   return mag_t'($urandom_range(0, 255));
      MAG_ALT:     return pos[0] ? mag_t'($urandom_range(0, 99))
                                 : mag_t'($urandom_range(1000, MAG_TOP));
      default:     return mag_t'($urandom());
    endcase
  endfunction

  task automatic offer_bin(mag_t m, logic is_last);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.magnitude <= m;
    in_bus.last      <= is_last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_frame(int unsigned n_bins, int style);
    int unsigned i;
    for (i = 0; i < n_bins; i++) offer_bin(pick_mag(style, i), i == n_bins - 1);
  endtask

  // extra edge first so the monitor has noted the word just accepted
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_span(span_cfg_t v);
    wait_idle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    cycle_count      = 0;
    src_idle_en      = 1'b1;
    rst_n            <= 1'b0;
    hold_off_req     <= 1'b0;
    snk_idle_en      <= 1'b1;
    in_bus.valid     <= 1'b0;
    in_bus.magnitude <= '0;
    in_bus.last      <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.data     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset span: plateau of full-scale ties, zeros
    offer_bin(24'd5, 1'b0);
    offer_bin('0, 1'b0);
    offer_bin(MAG_TOP, 1'b0);
    offer_bin(MAG_TOP, 1'b0);
    offer_bin(24'd3, 1'b0);
    offer_bin(MAG_TOP, 1'b0);
    offer_bin('0, 1'b1);
    // one-bin frame
    offer_bin('0, 1'b1);
    // span 0: every bin is its own window
    write_span(4'd0);
    offer_bin(24'd7, 1'b0);
    offer_bin(24'd7, 1'b0);
    offer_bin(24'd7, 1'b1);
    // oversized span clips to MAX_SPAN; a write mid-frame waits for the next frame
    write_span(4'd15);
    offer_bin(24'd1, 1'b0);
    offer_bin(24'd2, 1'b0);
    offer_bin(24'd3, 1'b0);
    write_span(4'd1);
    offer_bin(24'd9, 1'b0);
    offer_bin(24'd2, 1'b0);
    offer_bin(24'd1, 1'b1);
    offer_bin(MAG_TOP, 1'b0);
    offer_bin(MAG_TOP, 1'b1);

    rand_items = 0;
    frame_no   = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (frame_no == 3) begin
        // output held off while bins keep coming, then drain fully
        write_span(4'd1);
        hold_off_req <= 1'b1;
        send_frame(PRESS_LEN, MAG_ALT);
        wait_idle();
        rand_items += PRESS_LEN;
      end
      if ($urandom_range(0, 1) != 0)
        write_span(($urandom_range(0, 3) == 0) ? span_cfg_t'($urandom_range(0, 15))
                                               : span_cfg_t'($urandom_range(1, 8)));
      if (rand_items + 60 >= RANDOM_ITEMS) begin
        src_idle_en = 1'b0;
        snk_idle_en <= 1'b0;
      end else begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en <= ($urandom_range(0, 3) != 0);
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      send_frame(len, $urandom_range(MAG_FULL, MAG_ALT));
      rand_items += len;
      frame_no++;
    end

    wait_idle();
    repeat (QUIET_CYCLES) @(posedge clk);
    tracker.flush_leftovers();

    $display("Covered %0d bins: spans 0 to 15 over %0d span writes, ties, full-scale bins,",
             tracker.bins_seen, tracker.span_writes);
    $display("a span write inside a frame and a long output stall; %0d peaks, %0d end words ok",
             tracker.peaks_ok, tracker.markers_ok);
    if (tracker.errors == 0) begin
      $display("spectral_peak_picker regression: pass");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("spectral_peak_picker regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/spp_pkg.sv
src/spp_if.sv
src/spp_peak_cmp.sv
src/spectral_peak_picker.sv
sim/spectral_peak_picker_tb.sv
